/* design/ple_pkg.sv */
// Shared types and constants for the positional list engine.
package ple_pkg;

	localparam int DATA_W           = 32;
	localparam int POS_W            = 5;
	localparam int COUNT_OUT_W      = 5;
	localparam int CAPACITY_DEFAULT = 16;

	typedef enum logic [2:0] {
		CMD_INS_FRONT = 3'd0,
		CMD_INS_BACK  = 3'd1,
		CMD_INS_AT    = 3'd2,
		CMD_DEL_FRONT = 3'd3,
		CMD_DEL_BACK  = 3'd4,
		CMD_DEL_AT    = 3'd5,
		CMD_SEARCH    = 3'd6
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_EMPTY  = 2'd1,
		ST_BADPOS = 2'd2,
		ST_FULL   = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_REPORT
	} state_t;

	// Broadcast control from the sequencer to every cell.
	typedef struct packed {
		logic ins;
		logic del;
		logic search;
	} cell_ctl_t;

	typedef struct packed {
		logic [2:0]               command;
		logic signed [DATA_W-1:0] value;
		logic [POS_W-1:0]         position;
	} cmd_word_t;

	typedef struct packed {
		logic [1:0]               status;
		logic                     found;
		logic [COUNT_OUT_W-1:0]   count;
		logic signed [DATA_W-1:0] last_value;
		logic                     last_valid;
		logic signed [DATA_W-1:0] before_last_value;
		logic                     before_last_valid;
	} res_word_t;

endpackage

/* design/ple_cell.sv */
// One storage cell of the list chain, holding a single entry.
module ple_cell import ple_pkg::*; #(
	parameter int IDX   = 0,
	parameter int CNT_W = 5
) (
	input  logic                     clk,
	input  cell_ctl_t                ctl,
	input  logic [CNT_W-1:0]         k,
	input  logic [CNT_W-1:0]         cnt,
	input  logic signed [DATA_W-1:0] value,
	input  logic signed [DATA_W-1:0] lower,
	input  logic signed [DATA_W-1:0] upper,
	output logic signed [DATA_W-1:0] data,
	output logic                     match
);

	localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

	logic signed [DATA_W-1:0] data_q;
	logic                     match_q;
	logic                     occupied;

	assign occupied = MY_IDX < cnt;

	// Cells above the insertion point take their lower neighbour; from the
	// deletion point upwards they take their upper neighbour.
	always_ff @(posedge clk) begin
		if (ctl.ins) begin
			if (MY_IDX > k) begin
				data_q <= lower;
			end else if (MY_IDX == k) begin
				data_q <= value;
			end
		end else if (ctl.del) begin
			if (MY_IDX >= k) begin
				data_q <= upper;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.search) begin
			match_q <= occupied && (data_q == value);
		end
	end

	assign data  = data_q;
	assign match = match_q;

endmodule

/* design/positional_list_engine.sv */
// Top level of the positional list engine: sequencer and chain of list cells.
//
// The engine keeps a bounded ordered list of signed 32-bit values in a chain of
// CAPACITY identical cells. The list is held back to front: cell 0 always holds
// the last entry and cell 1 the entry before it, so the two values reported with
// every result come from fixed places. An insert or delete shifts the cells on
// one side of the affected place by one step towards their neighbour, all cells
// at once, and a search compares every occupied cell in parallel. Each command
// word yields exactly one result word. The result is offered once the command
// has passed the sequencer: the word is captured at acceptance, the cells
// shift or compare in the executing phase, and in the reporting phase the match
// flags are combined and the result register is loaded, which waits while an
// earlier result is still stalled in it. The small sequencer steps through
// three phases (waiting for a word, executing, reporting) and takes no new
// command until the last result has been loaded. A new command is taken while an
// earlier result still waits in the output register. Entries have no reset
// value; reset clears the count, the sequencer state and the result valid flag.
module positional_list_engine import ple_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEFAULT
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	output logic      cmd_stall,
	input  cmd_word_t cmd_word,
	output logic      res_valid,
	input  logic      res_stall,
	output res_word_t res_word
);

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);
	localparam logic [CNT_W-1:0] CNT_TWO  = CNT_W'(2);

	state_t state_q, state_d;

	// Command captured at acceptance.
	cmd_t                     cmd_q;
	logic signed [DATA_W-1:0] value_q;
	logic [POS_W-1:0]         pos_q;

	logic [CNT_W-1:0] cnt_q;
	status_t          status_q;

	logic      res_valid_q;
	res_word_t res_q;

	// Sequencer outputs.
	logic accept;
	logic exec_en;
	logic report_en;

	// Decoded command.
	status_t          status_d;
	logic             do_ins;
	logic             do_del;
	logic [CMP_W-1:0] k_x;
	logic [CMP_W-1:0] cnt_x;
	logic [CMP_W-1:0] pos_x;
	logic [CNT_W-1:0] k;
	cell_ctl_t        ctl;

	logic signed [DATA_W-1:0] cell_data [CAPACITY];
	logic [CAPACITY-1:0]      cell_match;

	logic             found;
	logic             last_ok;
	logic             before_last_ok;
	logic [CMP_W-1:0] cnt_out;
	res_word_t        res_d;

	// Next-state logic of the sequencer.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (cmd_valid) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				state_d = S_REPORT;
			end
			S_REPORT: begin
				if (!res_valid_q || !res_stall) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Output logic of the sequencer.
	always_comb begin
		cmd_stall = 1'b1;
		exec_en   = 1'b0;
		report_en = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				cmd_stall = 1'b0;
			end
			S_EXEC: begin
				exec_en = 1'b1;
			end
			S_REPORT: begin
				report_en = !res_valid_q || !res_stall;
			end
			default: begin
				cmd_stall = 1'b1;
			end
		endcase
	end

	assign accept = cmd_valid && !cmd_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q   <= cmd_t'(cmd_word.command);
			value_q <= cmd_word.value;
			pos_q   <= cmd_word.position;
		end
	end

	// Decode the command against the current count. The cell index k is the
	// place of the change counted from the back of the list.
	assign cnt_x = CMP_W'(cnt_q);
	assign pos_x = CMP_W'(pos_q);

	always_comb begin
		status_d = ST_OK;
		do_ins   = 1'b0;
		do_del   = 1'b0;
		k_x      = '0;
		unique case (cmd_q)
			CMD_INS_FRONT: begin
				if (cnt_q == CNT_FULL) begin
					status_d = ST_FULL;
				end else begin
					do_ins = 1'b1;
					k_x    = cnt_x;
				end
			end
			CMD_INS_BACK: begin
				if (cnt_q == CNT_FULL) begin
					status_d = ST_FULL;
				end else begin
					do_ins = 1'b1;
				end
			end
			CMD_INS_AT: begin
				if (cnt_q == CNT_FULL) begin
					status_d = ST_FULL;
				end else if (pos_x == '0 || pos_x > cnt_x + CMP_W'(1)) begin
					status_d = ST_BADPOS;
				end else begin
					do_ins = 1'b1;
					k_x    = cnt_x + CMP_W'(1) - pos_x;
				end
			end
			CMD_DEL_FRONT: begin
				if (cnt_q == '0) begin
					status_d = ST_EMPTY;
				end else begin
					do_del = 1'b1;
					k_x    = cnt_x - CMP_W'(1);
				end
			end
			CMD_DEL_BACK: begin
				if (cnt_q == '0) begin
					status_d = ST_EMPTY;
				end else begin
					do_del = 1'b1;
				end
			end
			CMD_DEL_AT: begin
				if (cnt_q == '0) begin
					status_d = ST_EMPTY;
				end else if (pos_x == '0 || pos_x > cnt_x) begin
					status_d = ST_BADPOS;
				end else begin
					do_del = 1'b1;
					k_x    = cnt_x - pos_x;
				end
			end
			default: begin
				status_d = ST_OK;
			end
		endcase
	end

	assign k          = k_x[CNT_W-1:0];
	assign ctl.ins    = exec_en && do_ins;
	assign ctl.del    = exec_en && do_del;
	assign ctl.search = exec_en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ctl.ins) begin
			cnt_q <= cnt_q + CNT_W'(1);
		end else if (ctl.del) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (exec_en) begin
			status_q <= status_d;
		end
	end

	// The chain of cells; the ends see zero from their missing neighbour.
	for (genvar r = 0; r < CAPACITY; r++) begin : g_cell
		logic signed [DATA_W-1:0] lower;
		logic signed [DATA_W-1:0] upper;

		if (r == 0) begin : g_first
			assign lower = '0;
		end else begin : g_lower
			assign lower = cell_data[r-1];
		end

		if (r == CAPACITY - 1) begin : g_last
			assign upper = '0;
		end else begin : g_upper
			assign upper = cell_data[r+1];
		end

		ple_cell #(
			.IDX   (r),
			.CNT_W (CNT_W)
		) u_cell (
			.clk   (clk),
			.ctl   (ctl),
			.k     (k),
			.cnt   (cnt_q),
			.value (value_q),
			.lower (lower),
			.upper (upper),
			.data  (cell_data[r]),
			.match (cell_match[r])
		);
	end

	// Result assembly: the match flags were registered in the cells, and the
	// back of the list sits in the two lowest cells.
	assign found          = (cmd_q == CMD_SEARCH) && (|cell_match);
	assign last_ok        = cnt_q != '0;
	assign before_last_ok = cnt_q >= CNT_TWO;
	assign cnt_out        = CMP_W'(cnt_q);

	always_comb begin
		res_d.status            = status_q;
		res_d.found             = found;
		res_d.count             = cnt_out[COUNT_OUT_W-1:0];
		res_d.last_value        = last_ok ? cell_data[0] : '0;
		res_d.last_valid        = last_ok;
		res_d.before_last_value = before_last_ok ? cell_data[1] : '0;
		res_d.before_last_valid = before_last_ok;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (report_en) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (report_en) begin
			res_q <= res_d;
		end
	end

	assign res_valid = res_valid_q;
	assign res_word  = res_q;

endmodule

/* tb/sv/positional_list_engine_tb.sv */
// Self-checking testbench for the positional list engine, with a scoreboard class that mirrors the list.
`timescale 1ns / 100ps

module positional_list_engine_tb;
	import ple_pkg::*;

	localparam int CLK_PERIOD = 10;
	localparam int LIST_DEPTH = CAPACITY_DEFAULT;
	localparam logic [2:0] CMD_UNUSED = 3'd7;
	localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
	localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;
	localparam int RANDOM_WORDS = 530;
	localparam int CALM_FROM = 470;
	localparam int HOLD_AT = 150;
	localparam int HOLD_CYCLES = 48;
	localparam int DRAIN_CYCLES = 12;
	localparam int LIMIT_NS = 400_000;

	typedef enum {LOAD_UP, DRAIN_DOWN, CHURN} phase_kind_t;

	// Mirror of the list, front of the list at index 0, and the result words it has
	// predicted but not yet seen from the engine.
	class list_shadow;
		logic signed [DATA_W-1:0] cells[$];
		res_word_t expected_results[$];
		int mismatch_count;

		function new();
			mismatch_count = 0;
		endfunction

		task report_mismatch(string msg);
			$display("MISMATCH at %0t: %s", $time, msg);
			mismatch_count++;
		endtask

		function int depth();
			return cells.size();
		endfunction

		function logic signed [DATA_W-1:0] pick_stored();
			if (cells.size() == 0)
				return $urandom;
			return cells[$urandom_range(0, cells.size() - 1)];
		endfunction

		function void note_command(cmd_word_t w);
			int n;
			int idx;
			status_t st;
			logic hit;
			res_word_t r;
			n = cells.size();
			st = ST_OK;
			hit = 1'b0;
			idx = 0;
			case (w.command)
				CMD_INS_FRONT, CMD_INS_BACK, CMD_INS_AT: begin
					if (w.command == CMD_INS_FRONT)
						idx = 0;
					else if (w.command == CMD_INS_BACK)
						idx = n;
					else
						idx = int'(w.position) - 1;
					if (n >= LIST_DEPTH)
						st = ST_FULL;
					else if (idx < 0 || idx > n)
						st = ST_BADPOS;
					else
						cells.insert(idx, w.value);
				end
				CMD_DEL_FRONT, CMD_DEL_BACK, CMD_DEL_AT: begin
					if (w.command == CMD_DEL_FRONT)
						idx = 0;
					else if (w.command == CMD_DEL_BACK)
						idx = n - 1;
					else
						idx = int'(w.position) - 1;
					if (n == 0)
						st = ST_EMPTY;
					else if (idx < 0 || idx >= n)
						st = ST_BADPOS;
					else
						cells.delete(idx);
				end
				CMD_SEARCH: begin
					foreach (cells[i])
						if (cells[i] == w.value)
							hit = 1'b1;
				end
				default: ;
			endcase
			n = cells.size();
			r.status = st;
			r.found = hit;
			r.count = n[COUNT_OUT_W-1:0];
			r.last_valid = (n >= 1);
			r.last_value = (n >= 1) ? cells[n-1] : '0;
			r.before_last_valid = (n >= 2);
			r.before_last_value = (n >= 2) ? cells[n-2] : '0;
			expected_results.push_back(r);
		endfunction

		task compare_field(string name, logic [31:0] got, logic [31:0] want);
			if (got !== want)
				report_mismatch($sformatf("%s: got %0h, expected %0h", name, got, want));
		endtask

		task check_result(res_word_t got);
			res_word_t want;
			if (expected_results.size() == 0) begin
				report_mismatch($sformatf("result word %h with no command outstanding", got));
				return;
			end
			want = expected_results.pop_front();
			compare_field("status", got.status, want.status);
			compare_field("found", got.found, want.found);
			compare_field("count", got.count, want.count);
			compare_field("last_value", got.last_value, want.last_value);
			compare_field("last_valid", got.last_valid, want.last_valid);
			compare_field("before_last_value", got.before_last_value, want.before_last_value);
			compare_field("before_last_valid", got.before_last_valid, want.before_last_valid);
		endtask

		task flush_leftovers();
			res_word_t want;
			while (expected_results.size() > 0) begin
				want = expected_results.pop_front();
				report_mismatch($sformatf("expected result word %h never arrived", want));
			end
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cmd_valid = 1'b0;
	logic cmd_stall;
	cmd_word_t cmd_word = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	res_word_t res_word;

	// Traffic shaping flags, set by the main sequence per phase. In the calm
	// stretch at the end neither side idles.
	bit calm = 1'b0;
	bit sender_idle = 1'b0;
	bit receiver_idle = 1'b0;
	int accepted_count = 0;

	list_shadow shadow;

	positional_list_engine uut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd_word(cmd_word),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res_word(res_word)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic cmd_word_t mk(logic [2:0] c, logic signed [DATA_W-1:0] v,
			logic [POS_W-1:0] p);
		cmd_word_t w;
		w.command = c;
		w.value = v;
		w.position = p;
		return w;
	endfunction

	function automatic logic [2:0] pick_insert();
		case ($urandom_range(0, 2))
			0: return CMD_INS_FRONT;
			1: return CMD_INS_BACK;
			default: return CMD_INS_AT;
		endcase
	endfunction

	function automatic logic [2:0] pick_delete();
		case ($urandom_range(0, 2))
			0: return CMD_DEL_FRONT;
			1: return CMD_DEL_BACK;
			default: return CMD_DEL_AT;
		endcase
	endfunction

	// Builds one random command word. The phase kind biases the mix of inserts
	// and deletes so that the list really does fill to capacity and drain to
	// empty, rather than hovering around a few entries. Positions are mostly
	// legal for the current depth, with the edges and the whole 5-bit range
	// mixed in; searches mostly look for a value that is actually stored.
	function automatic cmd_word_t next_word(phase_kind_t kind);
		cmd_word_t w;
		int n;
		int roll;
		int pick;
		n = shadow.depth();
		roll = $urandom_range(0, 99);
		case (kind)
			LOAD_UP: begin
				if (roll < 65)
					w.command = pick_insert();
				else if (roll < 80)
					w.command = CMD_SEARCH;
				else if (roll < 95)
					w.command = pick_delete();
				else
					w.command = 3'($urandom_range(CMD_INS_FRONT, CMD_UNUSED));
			end
			DRAIN_DOWN: begin
				if (roll < 65)
					w.command = pick_delete();
				else if (roll < 80)
					w.command = CMD_SEARCH;
				else if (roll < 95)
					w.command = pick_insert();
				else
					w.command = 3'($urandom_range(CMD_INS_FRONT, CMD_UNUSED));
			end
			default: begin
				if (roll < 40)
					w.command = pick_insert();
				else if (roll < 80)
					w.command = pick_delete();
				else if (roll < 95)
					w.command = CMD_SEARCH;
				else
					w.command = 3'($urandom_range(CMD_INS_FRONT, CMD_UNUSED));
			end
		endcase

		pick = $urandom_range(0, 9);
		if (pick == 0)
			w.position = POS_W'($urandom_range(0, 31));
		else if (pick == 1)
			w.position = POS_W'(n + $urandom_range(0, 2));
		else
			w.position = POS_W'($urandom_range(1, n + 1));

		pick = $urandom_range(0, 9);
		if (pick == 0) begin
			case ($urandom_range(0, 3))
				0: w.value = VAL_MIN;
				1: w.value = VAL_MAX;
				2: w.value = '0;
				default: w.value = -32'sd1;
			endcase
		end else if (pick < 3 || (w.command == CMD_SEARCH && pick < 7)) begin
			w.value = shadow.pick_stored();
		end else begin
			w.value = $urandom;
		end
		return w;
	endfunction

	// Offers one command word and holds it until the engine takes it. Words are
	// driven on the falling edge; acceptance is judged on the rising edge from
	// the stall value that was settled before it.
	task automatic send_word(cmd_word_t w);
		int gap;
		if (!calm && sender_idle && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 3);
			@(negedge clk);
			cmd_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		cmd_valid <= 1'b1;
		cmd_word <= w;
		do @(posedge clk); while (cmd_stall);
		shadow.note_command(w);
		accepted_count++;
	endtask

	// Result side: stall is driven on the falling edge, in short random bursts
	// while the phase allows it. Once, early in the random part, the receiver
	// holds off for a long stretch so that the output register stays full and
	// the engine has to stall the command side while words keep being offered.
	initial begin
		int burst;
		bit held;
		burst = 0;
		held = 1'b0;
		forever begin
			@(negedge clk);
			if (!held && accepted_count >= HOLD_AT) begin
				held = 1'b1;
				burst = HOLD_CYCLES;
			end
			if (burst > 0) begin
				res_stall <= 1'b1;
				burst--;
			end else if (!calm && receiver_idle && $urandom_range(0, 5) == 0) begin
				res_stall <= 1'b1;
				burst = $urandom_range(0, 2);
			end else begin
				res_stall <= 1'b0;
			end
		end
	end

	// Every accepted result word is checked against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall)
			shadow.check_result(res_word);
	end

	initial begin
		cmd_word_t directed[$];
		int made;
		int k;
		int phase_len;
		phase_kind_t kind;

		shadow = new();
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		// Directed opening: every command but INS_BACK and INS_AT on the empty list, the value extremes,
		// positions below and above the legal range for both inserts and deletes,
		// a hit and a miss, the unused command code, and a return to empty.
		directed.push_back(mk(CMD_SEARCH, '0, 5'd1));
		directed.push_back(mk(CMD_DEL_FRONT, '0, 5'd1));
		directed.push_back(mk(CMD_DEL_BACK, '0, 5'd1));
		directed.push_back(mk(CMD_DEL_AT, '0, 5'd1));
		directed.push_back(mk(CMD_UNUSED, -32'sd1, 5'd31));
		directed.push_back(mk(CMD_INS_FRONT, VAL_MIN, 5'd0));
		directed.push_back(mk(CMD_INS_BACK, VAL_MAX, 5'd31));
		directed.push_back(mk(CMD_INS_AT, 32'sd5, 5'd0));
		directed.push_back(mk(CMD_INS_AT, 32'sd6, 5'd4));
		directed.push_back(mk(CMD_INS_AT, 32'sd7, 5'd31));
		directed.push_back(mk(CMD_INS_AT, '0, 5'd3));
		directed.push_back(mk(CMD_INS_AT, -32'sd1, 5'd1));
		directed.push_back(mk(CMD_SEARCH, VAL_MIN, 5'd0));
		directed.push_back(mk(CMD_SEARCH, 32'sd1, 5'd0));
		directed.push_back(mk(CMD_DEL_AT, '0, 5'd0));
		directed.push_back(mk(CMD_DEL_AT, '0, 5'd5));
		directed.push_back(mk(CMD_DEL_AT, '0, 5'd4));
		directed.push_back(mk(CMD_DEL_AT, '0, 5'd2));
		directed.push_back(mk(CMD_UNUSED, VAL_MAX, 5'd16));
		directed.push_back(mk(CMD_DEL_BACK, '0, 5'd0));
		directed.push_back(mk(CMD_DEL_FRONT, '0, 5'd0));
		directed.push_back(mk(CMD_SEARCH, VAL_MIN, 5'd0));
		foreach (directed[i])
			send_word(directed[i]);

		// Random part: phases that alternately fill the list, drain it and churn
		// it, each with its own choice of whether either side idles.
		made = 0;
		k = 0;
		while (made < RANDOM_WORDS) begin
			kind = phase_kind_t'(k % 3);
			k++;
			phase_len = $urandom_range(30, 70);
			sender_idle = ($urandom_range(0, 3) != 0);
			receiver_idle = ($urandom_range(0, 3) != 0);
			repeat (phase_len) begin
				if (made < RANDOM_WORDS) begin
					calm = (made >= CALM_FROM);
					send_word(next_word(kind));
					made++;
				end
			end
		end

		@(negedge clk);
		cmd_valid <= 1'b0;
		while (shadow.expected_results.size() > 0)
			@(posedge clk);
		// Keep clocking so that any stray extra result word shows up.
		repeat (DRAIN_CYCLES) @(posedge clk);
		shadow.flush_leftovers();
		if (shadow.mismatch_count == 0)
			$display("positional_list_engine_tb: done, clean");
		else
			$display("positional_list_engine_tb: done, errors");
		$finish;
	end

	initial begin
		#(LIMIT_NS);
		$display("TIMEOUT at %0t", $time);
		$display("positional_list_engine_tb: done, errors");
		$finish;
	end

endmodule

/* filelist.f */
design/ple_pkg.sv
design/ple_cell.sv
design/positional_list_engine.sv
tb/sv/positional_list_engine_tb.sv
